### hw/rtl/move_to_front_history_list_assert.svh
// assertion macros for the move-to-front history list
// used by the top level; expects a clock named clk and a reset named rst
`ifndef MOVE_TO_FRONT_HISTORY_LIST_ASSERT_SVH
`define MOVE_TO_FRONT_HISTORY_LIST_ASSERT_SVH

// condition holds at every edge out of reset
`define MTFHL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent at the same edge
`define MTFHL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent at the next edge
`define MTFHL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mtfhl_pkg.sv
// shared types and constants for the move-to-front history list
// no dependencies
package mtfhl_pkg;

  localparam int ID_W   = 32;
  localparam int KIND_W = 8;
  localparam int TAG_W  = 64;
  localparam int POS_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // per-cell control broadcast from the top level
  typedef struct packed {
    logic cmp_en;
    logic move_en;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MOVE = 3'b100
  } state_t;

endpackage

### hw/rtl/mtfhl_cell.sv
// one list position: holds an entry, compares it against the request key
// and takes its neighbor's entry on a shift; depends on mtfhl_pkg
module mtfhl_cell (
  input  logic                             clk,
  input  mtfhl_pkg::cell_ctl_t             ctl,
  input  logic [mtfhl_pkg::ID_W-1:0]       key_id,
  input  logic [mtfhl_pkg::KIND_W-1:0]     key_kind,
  input  logic                             valid_in,
  input  logic                             shift,
  input  mtfhl_pkg::entry_t                prev,
  output mtfhl_pkg::entry_t                ent,
  output logic                             match
);

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match <= valid_in && (ent.id == key_id) && (ent.kind == key_kind);
    end
    if (ctl.move_en && shift) begin
      ent <= prev;
    end
  end

endmodule

### hw/rtl/mtfhl_scan.sv
// suffix-or of the match flags, hit position encoder and hit payload select
// outputs are registered; depends on mtfhl_pkg
module mtfhl_scan #(
  parameter  int DEPTH = 64,
  localparam int PosW  = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [DEPTH-1:0]            match,
  input  logic [mtfhl_pkg::TAG_W-1:0] tags [DEPTH],
  output logic [DEPTH-1:0]            shift,
  output logic                        hit,
  output logic [PosW-1:0]             pos,
  output logic [mtfhl_pkg::TAG_W-1:0] sel_tag
);

  localparam int Lvl = $clog2(DEPTH);

  logic [DEPTH-1:0] suf [Lvl+1];
  logic [DEPTH-1:0] pos_mask [PosW];
  logic [DEPTH-1:0] tag_col [mtfhl_pkg::TAG_W];
  logic [PosW-1:0]  pos_c;
  logic [mtfhl_pkg::TAG_W-1:0] tag_c;

  // log-step prefix network: suf[Lvl][k] is the or of match[DEPTH-1:k]
  always_comb begin
    suf[0] = match;
    for (int i = 0; i < Lvl; i++) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (k + (1 << i) < DEPTH) begin
          suf[i+1][k] = suf[i][k] | suf[i][k + (1 << i)];
        end else begin
          suf[i+1][k] = suf[i][k];
        end
      end
    end
  end

  // at most one cell matches, so an or-encoder gives its index
  always_comb begin
    logic [PosW-1:0] kv;
    kv = '0;
    for (int k = 0; k < DEPTH; k++) begin
      kv = PosW'(k);
      for (int b = 0; b < PosW; b++) begin
        pos_mask[b][k] = kv[b];
      end
    end
    for (int b = 0; b < PosW; b++) begin
      pos_c[b] = |(match & pos_mask[b]);
    end
  end

  always_comb begin
    for (int t = 0; t < mtfhl_pkg::TAG_W; t++) begin
      for (int k = 0; k < DEPTH; k++) begin
        tag_col[t][k] = tags[k][t];
      end
    end
    for (int t = 0; t < mtfhl_pkg::TAG_W; t++) begin
      tag_c[t] = |(match & tag_col[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= suf[Lvl][0];
      // a miss shifts every position back, a hit only those up to the hit
      shift   <= suf[Lvl][0] ? suf[Lvl] : '1;
      pos     <= pos_c;
      sel_tag <= tag_c;
    end
  end

endmodule

### hw/rtl/move_to_front_history_list.sv
// move-to-front history list: top level, a chain of list cells plus scan logic
// depends on mtfhl_pkg, mtfhl_cell, mtfhl_scan and the assertion macro header
// a request passes compare at accept, then scan, then move; result valid is set by the move
// a new request is taken only after the previous one commits; one request in flight
// reset clears the entry count and control; stored entries are not cleared
`include "move_to_front_history_list_assert.svh"
module move_to_front_history_list #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [mtfhl_pkg::ID_W-1:0]           item_id,
  input  logic [mtfhl_pkg::KIND_W-1:0]         item_kind,
  input  logic [mtfhl_pkg::TAG_W-1:0]          item_tag,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 was_present,
  output logic [mtfhl_pkg::POS_OUT_W-1:0]      found_position,
  output logic [mtfhl_pkg::CNT_OUT_W-1:0]      entries_after,
  output logic                                 oldest_dropped
);

  localparam int PosW = $clog2(LIST_DEPTH);
  localparam int CntW = $clog2(LIST_DEPTH + 1);

  mtfhl_pkg::state_t state, state_next;

  logic [CntW-1:0] count, count_next;
  logic [mtfhl_pkg::ID_W-1:0]   key_id;
  logic [mtfhl_pkg::KIND_W-1:0] key_kind;
  logic [mtfhl_pkg::TAG_W-1:0]  key_tag;

  mtfhl_pkg::cell_ctl_t ctl;
  mtfhl_pkg::entry_t    ents [LIST_DEPTH];
  mtfhl_pkg::entry_t    head;
  logic [mtfhl_pkg::TAG_W-1:0] tags [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_vec;
  logic [LIST_DEPTH-1:0] cell_valid;
  logic [LIST_DEPTH-1:0] shift_vec;

  logic            hit;
  logic [PosW-1:0] pos;
  logic [mtfhl_pkg::TAG_W-1:0] sel_tag;

  logic accept;
  logic commit;
  logic full;
  logic [CntW+mtfhl_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic [PosW+mtfhl_pkg::POS_OUT_W-1:0] pos_ext;

  assign item_stall = (state != mtfhl_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign commit     = (state == mtfhl_pkg::S_MOVE) && (!result_valid || !result_stall);
  assign full       = (count == CntW'(LIST_DEPTH));

  assign ctl = '{cmp_en: accept, move_en: commit};

  // cell 0 takes the request key; a hit keeps its old payload
  assign head = '{id: key_id, kind: key_kind, tag: (hit ? sel_tag : key_tag)};

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    mtfhl_pkg::entry_t prev;
    if (k == 0) begin : g_head
      assign prev = head;
    end else begin : g_link
      assign prev = ents[k-1];
    end
    assign cell_valid[k] = (count > CntW'(k));
    assign tags[k]       = ents[k].tag;

    mtfhl_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_id   (item_id),
      .key_kind (item_kind),
      .valid_in (cell_valid[k]),
      .shift    (shift_vec[k]),
      .prev     (prev),
      .ent      (ents[k]),
      .match    (match_vec[k])
    );
  end

  mtfhl_scan #(
    .DEPTH (LIST_DEPTH)
  ) u_scan (
    .clk     (clk),
    .en      (state == mtfhl_pkg::S_SCAN),
    .match   (match_vec),
    .tags    (tags),
    .shift   (shift_vec),
    .hit     (hit),
    .pos     (pos),
    .sel_tag (sel_tag)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mtfhl_pkg::S_IDLE: begin
        if (accept) state_next = mtfhl_pkg::S_SCAN;
      end
      mtfhl_pkg::S_SCAN: begin
        state_next = mtfhl_pkg::S_MOVE;
      end
      mtfhl_pkg::S_MOVE: begin
        if (commit) state_next = mtfhl_pkg::S_IDLE;
      end
      default: begin
        state_next = mtfhl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (hit || full) begin
      count_next = count;
    end else begin
      count_next = count + CntW'(1);
    end
  end

  assign cnt_ext = (CntW + mtfhl_pkg::CNT_OUT_W)'(count_next);
  assign pos_ext = (PosW + mtfhl_pkg::POS_OUT_W)'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mtfhl_pkg::S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_id   <= item_id;
      key_kind <= item_kind;
      key_tag  <= item_tag;
    end
    if (commit) begin
      was_present    <= hit;
      found_position <= pos_ext[mtfhl_pkg::POS_OUT_W-1:0];
      entries_after  <= cnt_ext[mtfhl_pkg::CNT_OUT_W-1:0];
      oldest_dropped <= !hit && full;
    end
  end

  `MTFHL_ASSERT_ALWAYS(a_count_bound, count <= CntW'(LIST_DEPTH), "entry count beyond depth")
  `MTFHL_ASSERT_IMPLY(a_single_match, state == mtfhl_pkg::S_SCAN, $onehot0(match_vec),
    "more than one cell matches the key")
  `MTFHL_ASSERT_NEXT(a_hit_keeps_count, commit && hit, count == $past(count),
    "hit changed the entry count")
  `MTFHL_ASSERT_NEXT(a_drop_stays_full, commit && !hit && full,
    oldest_dropped && count == CntW'(LIST_DEPTH), "drop on a full list lost the count")

endmodule
